### hw/rtl/multi_owner_deadline_registry_unit_defines.svh
// Assertion helpers for the deadline registry.
`ifndef MULTI_OWNER_DEADLINE_REGISTRY_UNIT_DEFINES_SVH
`define MULTI_OWNER_DEADLINE_REGISTRY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mdr_pkg.sv
package mdr_pkg;

  localparam int TIME_W = 32;
  localparam int CMD_W  = 2;
  localparam int OWN_W  = 3;

  typedef logic [TIME_W-1:0] time_ms_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_CONSUME  = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  // Request to the shared unit: a +/- b, and cmp_a < cmp_b.
  typedef struct packed {
    alu_op_t  op;
    time_ms_t a;
    time_ms_t b;
    time_ms_t cmp_a;
    time_ms_t cmp_b;
  } alu_req_t;

  typedef struct packed {
    time_ms_t sum;
    logic     lt;
  } alu_rsp_t;

  // diff = due - now. Reached when (now - due) as signed is >= 0, i.e. when
  // -diff has a clear sign bit: diff is zero, or negative but not the most negative value.
  function automatic logic is_reached(input time_ms_t diff);
    logic nz_low;
    nz_low = |diff[TIME_W-2:0];
    return (diff == '0) || (diff[TIME_W-1] && nz_low);
  endfunction

endpackage

### hw/rtl/mdr_alu.sv
module mdr_alu
  import mdr_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [TIME_W:0] cmp_diff;

  always_comb begin
    if (req.op == ALU_ADD) begin
      rsp.sum = req.a + req.b;
    end else begin
      rsp.sum = req.a - req.b;
    end
    // unsigned less-than from the borrow out
    cmp_diff = {1'b0, req.cmp_a} - {1'b0, req.cmp_b};
    rsp.lt   = cmp_diff[TIME_W];
  end

endmodule

### hw/rtl/multi_owner_deadline_registry_unit.sv
// Channel   Dir  Handshake            Payload (low bit first)
// s_axis    in   tvalid/tready        tuser: command; tdata: owner, now_ms, span_ms
// m_axis    out  tvalid/tready        tuser: status, consumed_any, any_armed;
//                                     tdata: next_span_ms
//
// One transaction at a time through a shared subtract/add/compare unit.
// Schedule with a valid owner passes ST_SDIFF and ST_SWR before the owner scan;
// every other command goes straight to the scan, and each ends in ST_DONE.
// tready is back in the same cycle as the result turns valid. The owner scan
// takes one slot per cycle. A finished result waits in the output register
// while the next transaction is taken and worked on; the one after that
// stalls until the held result is taken.
// rst is synchronous, active high; it disarms every owner.
`include "multi_owner_deadline_registry_unit_defines.svh"

module multi_owner_deadline_registry_unit
  import mdr_pkg::*;
#(
  parameter int OWNER_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // owner[2:0], now_ms[34:3], span_ms[66:35], zeros
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // next_span_ms[31:0]
  output logic [2:0]  m_axis_tuser   // status[0], consumed_any[1], any_armed[2]
);

  localparam int IDX_W = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OWNER_COUNT - 1);
  localparam logic [OWN_W:0]   OWNER_LIM = (OWN_W + 1)'(OWNER_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SDIFF,
    ST_SWR,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic [OWN_W-1:0]    owner;
  time_ms_t            now_ms;
  time_ms_t            span_ms;
  logic [IDX_W-1:0]    cnt;
  logic [OWNER_COUNT-1:0] armed;
  time_ms_t            deadlines [OWNER_COUNT];
  time_ms_t            sched_diff;
  logic                sched_reached;
  logic                status;
  logic                consumed;
  logic                found;
  time_ms_t            best;

  cmd_t                in_cmd;
  logic [OWN_W-1:0]    in_owner;
  logic                in_range;
  logic                accept;
  logic [IDX_W-1:0]    rd_idx;
  time_ms_t            rd_data;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic                cur_reached;
  time_ms_t            cand;
  logic                dl_we;

  assign in_cmd        = cmd_t'(s_axis_tuser);
  assign in_owner      = s_axis_tdata[OWN_W-1:0];
  assign in_range      = {1'b0, in_owner} < OWNER_LIM;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // single read port: scan slot or the scheduled owner
  assign rd_idx  = (state == ST_SCAN) ? cnt : owner[IDX_W-1:0];
  assign rd_data = deadlines[rd_idx];

  mdr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    alu_req.op    = ALU_SUB;
    alu_req.a     = rd_data;
    alu_req.b     = now_ms;
    alu_req.cmp_a = cand;
    alu_req.cmp_b = best;
    if (state == ST_SWR) begin
      alu_req.op    = ALU_ADD;
      alu_req.a     = now_ms;
      alu_req.b     = span_ms;
      alu_req.cmp_a = span_ms;
      alu_req.cmp_b = sched_diff;
    end
  end

  assign cur_reached = is_reached(alu_rsp.sum);
  assign cand        = cur_reached ? '0 : alu_rsp.sum;
  assign dl_we       = (state == ST_SWR) &&
                       (!armed[owner[IDX_W-1:0]] || (!sched_reached && alu_rsp.lt));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OWNER_COUNT; i++) begin
        deadlines[i] <= '0;
      end
    end else if (dl_we) begin
      deadlines[owner[IDX_W-1:0]] <= alu_rsp.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      armed         <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // ST_DONE drives tvalid itself
      if (m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd      <= in_cmd;
            owner    <= in_owner;
            now_ms   <= s_axis_tdata[34:3];
            span_ms  <= s_axis_tdata[66:35];
            status   <= 1'b0;
            consumed <= 1'b0;
            found    <= 1'b0;
            best     <= '0;
            cnt      <= '0;
            state    <= ST_SCAN;
            if (in_cmd == CMD_SCHEDULE || in_cmd == CMD_CANCEL) begin
              if (!in_range) begin
                status <= 1'b1;
              end else if (in_cmd == CMD_SCHEDULE) begin
                state <= ST_SDIFF;
              end else begin
                armed[in_owner[IDX_W-1:0]] <= 1'b0;
              end
            end
          end
        end
        ST_SDIFF: begin
          sched_diff    <= alu_rsp.sum;
          sched_reached <= cur_reached;
          state         <= ST_SWR;
        end
        ST_SWR: begin
          armed[owner[IDX_W-1:0]] <= 1'b1;
          state                   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (armed[cnt]) begin
            if (cmd == CMD_CONSUME && cur_reached) begin
              armed[cnt] <= 1'b0;
              consumed   <= 1'b1;
            end else if (!found || alu_rsp.lt) begin
              found <= 1'b1;
              best  <= cand;
            end
          end
          if (cnt == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= found ? best : '0;
            m_axis_tuser  <= {found, consumed, status};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MDR_ASSERT_NEXT(a_non_sched_scans, accept && (in_cmd != CMD_SCHEDULE || !in_range), state == ST_SCAN, "command skipped the scan")
  `MDR_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata == '0, "delay reported with nothing armed")
  `MDR_ASSERT_NOW(a_consume_ok, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "consume result carries an error")
  `MDR_ASSERT_NOW(a_cnt_range, state == ST_SCAN, cnt <= LAST_IDX, "scan index past last owner")

endmodule

### test/deadline_registry_monitor.sv
`timescale 1ns / 1ps

module deadline_registry_monitor
  import mdr_pkg::*;
#(
  parameter int OWNER_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // owner[2:0], now_ms[34:3], span_ms[66:35], zeros
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // next_span_ms[31:0]
  input  logic [2:0]  m_axis_tuser,  // status[0], consumed_any[1], any_armed[2]
  output int          mismatch_count,
  output int          replies_due
);

  typedef struct packed {
    logic     status;
    logic     consumed_any;
    logic     any_armed;
    time_ms_t next_span_ms;
  } reply_t;

  time_ms_t                 due_at [OWNER_COUNT];
  logic [OWNER_COUNT-1:0]   armed;
  reply_t                   awaited_replies [$];

  initial begin
    mismatch_count = 0;
    replies_due    = 0;
  end

  // Wrap-aware: due is reached once now - due is non-negative as a signed value.
  function automatic logic reached(input time_ms_t now_ms, input time_ms_t due);
    time_ms_t gap;
    gap = now_ms - due;
    return ~gap[31];
  endfunction

  function automatic reply_t next_reply(input cmd_t cmd, input logic [2:0] owner,
                                        input time_ms_t now_ms, input time_ms_t span_ms);
    reply_t   r;
    time_ms_t left;
    r = '0;
    case (cmd)
      CMD_SCHEDULE, CMD_CANCEL: begin
        if (owner >= OWNER_COUNT) begin
          r.status = 1'b1;
        end else if (cmd == CMD_SCHEDULE) begin
          // only pull an unreached deadline closer, never push it out
          if (!armed[owner] ||
              (!reached(now_ms, due_at[owner]) && span_ms < due_at[owner] - now_ms))
            due_at[owner] = now_ms + span_ms;
          armed[owner] = 1'b1;
        end else begin
          armed[owner] = 1'b0;
        end
      end
      CMD_CONSUME: begin
        for (int i = 0; i < OWNER_COUNT; i++) begin
          if (armed[i] && reached(now_ms, due_at[i])) begin
            armed[i]       = 1'b0;
            r.consumed_any = 1'b1;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < OWNER_COUNT; i++) begin
      if (armed[i]) begin
        left = reached(now_ms, due_at[i]) ? '0 : due_at[i] - now_ms;
        if (!r.any_armed || left < r.next_span_ms) begin
          r.any_armed    = 1'b1;
          r.next_span_ms = left;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_reply(input string what, input reply_t want, input reply_t got);
    if (mismatch_count < 10)
      $display("%0t: %s: expected st %0b cons %0b armed %0b delay %0d, got st %0b cons %0b armed %0b delay %0d",
               $realtime, what, want.status, want.consumed_any, want.any_armed,
               want.next_span_ms, got.status, got.consumed_any, got.any_armed,
               got.next_span_ms);
    mismatch_count <= mismatch_count + 1;
  endtask

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int i = 0; i < OWNER_COUNT; i++) due_at[i] = '0;
      armed = '0;
      awaited_replies.delete();
      replies_due <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status: m_axis_tuser[0], consumed_any: m_axis_tuser[1],
                any_armed: m_axis_tuser[2], next_span_ms: m_axis_tdata};
        if (awaited_replies.size() == 0) begin
          flag_reply("unexpected reply", '0, got);
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) flag_reply("reply mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_replies.push_back(next_reply(cmd_t'(s_axis_tuser), s_axis_tdata[2:0],
                                             s_axis_tdata[34:3], s_axis_tdata[66:35]));
      replies_due <= awaited_replies.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mdr_pkg::*;

  localparam int OWNERS       = 4;
  localparam int RANDOM_ITEMS = 1800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_QUERY;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;

  int          mismatch_count;
  int          replies_due;

  logic        calm = 1'b0;      // no idling on either side near the end
  int          tx_odds = 0;      // 0: no gaps, else one chance in tx_odds per item
  int          rx_odds = 0;
  int          stall_left = 0;
  int          rx_cycles = 0;
  time_ms_t    clock_ms;

  multi_owner_deadline_registry_unit #(.OWNER_COUNT(OWNERS)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  deadline_registry_monitor #(.OWNER_COUNT(OWNERS)) monitor (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .mismatch_count(mismatch_count), .replies_due(replies_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure: random-length stall bursts, with the odds redrawn
  // on the rx_cycles counter so some stretches run without stalls.
  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles % 512 == 0) begin
      case ($urandom_range(0, 2))
        0:       rx_odds <= 0;
        1:       rx_odds <= 3;
        default: rx_odds <= 10;
      endcase
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic issue(input cmd_t cmd, input logic [2:0] owner,
                       input time_ms_t now_ms, input time_ms_t span_ms);
    if (!calm && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, span_ms, now_ms, owner};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    int       pick;
    cmd_t     cmd;
    logic [2:0] owner;
    time_ms_t span_ms;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_odds = 4;

    // directed: empty registry, move rules, out-of-range owners, wrap, extremes
    issue(CMD_QUERY,    3'd0, 32'd0,         32'd0);
    issue(CMD_CONSUME,  3'd0, 32'd0,         32'd0);
    issue(CMD_SCHEDULE, 3'd0, 32'd100,       32'd50);
    issue(CMD_SCHEDULE, 3'd0, 32'd110,       32'd100);  // further out: kept
    issue(CMD_SCHEDULE, 3'd0, 32'd110,       32'd10);   // nearer: moved
    issue(CMD_SCHEDULE, 3'd4, 32'd110,       32'd1);
    issue(CMD_CANCEL,   3'd7, 32'd110,       32'd0);
    issue(CMD_SCHEDULE, 3'd3, 32'd200,       32'd0);    // due right away
    issue(CMD_SCHEDULE, 3'd3, 32'd300,       32'd5);    // reached: kept
    issue(CMD_QUERY,    3'd5, 32'd300,       32'hFFFF_FFFF);
    issue(CMD_CONSUME,  3'd6, 32'd300,       32'hFFFF_FFFF);
    issue(CMD_CONSUME,  3'd0, 32'd301,       32'd0);    // nothing left to clear
    issue(CMD_SCHEDULE, 3'd1, 32'hFFFF_FFF0, 32'h20);   // deadline wraps past zero
    issue(CMD_QUERY,    3'd0, 32'hFFFF_FFFF, 32'd0);
    issue(CMD_CONSUME,  3'd0, 32'h0000_0010, 32'd0);
    issue(CMD_SCHEDULE, 3'd2, 32'd0,         32'h7FFF_FFFF);
    issue(CMD_SCHEDULE, 3'd1, 32'd0,         32'h8000_0000);
    issue(CMD_SCHEDULE, 3'd0, 32'd0,         32'hFFFF_FFFF);
    issue(CMD_QUERY,    3'd0, 32'd1,         32'd0);
    issue(CMD_CANCEL,   3'd2, 32'd1,         32'd0);
    issue(CMD_CANCEL,   3'd2, 32'd1,         32'd0);    // already disarmed
    issue(CMD_SCHEDULE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_CONSUME,  3'd7, 32'hFFFF_FFFF, 32'd0);
    issue(CMD_QUERY,    3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random: a clock that mostly creeps forward so deadlines come due,
    // with jumps anywhere and to just below the sign and wrap boundaries
    clock_ms = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      if (i == RANDOM_ITEMS - 150) calm = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 2)
        clock_ms = $urandom;
      else if (pick < 4)
        clock_ms = (($urandom_range(0, 1) != 0) ? 32'h7FFF_FF00 : 32'hFFFF_FF00)
                   + $urandom_range(0, 255);
      else
        clock_ms = clock_ms + $urandom_range(0, 40);

      pick = $urandom_range(0, 99);
      if (pick < 40)      cmd = CMD_SCHEDULE;
      else if (pick < 55) cmd = CMD_CANCEL;
      else if (pick < 80) cmd = CMD_CONSUME;
      else                cmd = CMD_QUERY;

      owner = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                          : 3'($urandom_range(0, OWNERS - 1));

      pick = $urandom_range(0, 99);
      if (pick < 70)      span_ms = $urandom_range(0, 120);
      else if (pick < 85) span_ms = $urandom;
      else                span_ms = 32'h7FFF_FFF0 + $urandom_range(0, 31);

      issue(cmd, owner, clock_ms, span_ms);
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && replies_due == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
